// File: sv/vertex_view_angles_defines.svh
// Assertion macros shared by the vertex view angle RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef VERTEX_VIEW_ANGLES_DEFINES_SVH
`define VERTEX_VIEW_ANGLES_DEFINES_SVH
`ifndef ASSERT_OFF
`define VVA_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("vertex_view_angles check failed");
`define VVA_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("vertex_view_angles check failed");
`else
`define VVA_ASSERT(lbl, clk, rstn, prop)
`define VVA_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// File: sv/vva_pkg.sv
// Types, widths and constants for the vertex view angle pipeline.
// No dependencies; imported by every module of the block.
package vva_pkg;
    localparam int DATA_W   = 32;
    localparam int ROW_W    = 54;
    localparam int BASIS_W  = 18;
    localparam int DIFF_W   = 33;
    localparam int PROD_W   = 51;
    localparam int T_W      = 53;
    localparam int MAG_W    = 53;
    localparam int SH_W     = 6;
    localparam int CW       = 64;
    localparam int ACC_W    = 26;
    localparam int ANG_W    = 16;
    localparam int ATAN_LEN = 24;
    localparam int NORM_MSB = 58;
    localparam int Q7_SHIFT = 9;

    localparam logic signed [ACC_W-1:0] DEG90_Q16  = 26'sd5898240;
    localparam logic signed [ACC_W-1:0] DEG180_Q16 = 26'sd11796480;
    localparam logic signed [ACC_W-1:0] ROUND_Q7   = 26'sd256;
    localparam logic signed [ANG_W-1:0] DEG90_Q7   = 16'sd11520;
    localparam logic signed [ANG_W-1:0] DEG180_Q7  = 16'sd23040;

    localparam logic [ROW_W-1:0] ROW_X_RST = 54'd65536;
    localparam logic [ROW_W-1:0] ROW_Y_RST = 54'd17179869184;
    localparam logic [ROW_W-1:0] ROW_Z_RST = 54'd4503599627370496;

    typedef enum logic [2:0] {
        REG_CAM_POS_X   = 3'd0,
        REG_CAM_POS_Y   = 3'd1,
        REG_CAM_POS_Z   = 3'd2,
        REG_BASIS_ROW_X = 3'd3,
        REG_BASIS_ROW_Y = 3'd4,
        REG_BASIS_ROW_Z = 3'd5
    } vva_reg_t;

    // Special-case marks that travel with each lane.
    typedef struct packed {
        logic a_zero;
        logic z_zero;
        logic a_neg;
        logic z_neg;
    } vva_case_t;

    // atan(2^-i) in degrees, Q.16, scaled by 180/3.14159.
    function automatic logic [21:0] atan_deg_q16(input logic [4:0] i);
        logic [21:0] v;
        case (i)
            5'd0:  v = 22'd2949122;
            5'd1:  v = 22'd1740969;
            5'd2:  v = 22'd919880;
            5'd3:  v = 22'd466945;
            5'd4:  v = 22'd234379;
            5'd5:  v = 22'd117304;
            5'd6:  v = 22'd58666;
            5'd7:  v = 22'd29335;
            5'd8:  v = 22'd14668;
            5'd9:  v = 22'd7334;
            5'd10: v = 22'd3667;
            5'd11: v = 22'd1833;
            5'd12: v = 22'd917;
            5'd13: v = 22'd458;
            5'd14: v = 22'd229;
            5'd15: v = 22'd115;
            5'd16: v = 22'd57;
            5'd17: v = 22'd29;
            5'd18: v = 22'd14;
            5'd19: v = 22'd7;
            5'd20: v = 22'd4;
            5'd21: v = 22'd2;
            5'd22: v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction
endpackage

// File: sv/vva_xform.sv
// Camera-space transform: subtract camera position, 3x3 basis multiply.
// Three register stages; depends on vva_pkg.
module vva_xform (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic signed [vva_pkg::DATA_W-1:0] vx,
    input  logic signed [vva_pkg::DATA_W-1:0] vy,
    input  logic signed [vva_pkg::DATA_W-1:0] vz,
    input  logic signed [vva_pkg::DATA_W-1:0] pos_x,
    input  logic signed [vva_pkg::DATA_W-1:0] pos_y,
    input  logic signed [vva_pkg::DATA_W-1:0] pos_z,
    input  logic [vva_pkg::ROW_W-1:0]         row_x,
    input  logic [vva_pkg::ROW_W-1:0]         row_y,
    input  logic [vva_pkg::ROW_W-1:0]         row_z,
    output logic                              out_valid,
    output logic signed [vva_pkg::T_W-1:0]    tx,
    output logic signed [vva_pkg::T_W-1:0]    ty,
    output logic signed [vva_pkg::T_W-1:0]    tz
);
    import vva_pkg::*;

    logic [2:0]                valid_reg;
    logic signed [DIFF_W-1:0]  d_reg [3];
    logic signed [DIFF_W-1:0]  d_next [3];
    logic signed [PROD_W-1:0]  prod_reg [9];
    logic signed [PROD_W-1:0]  prod_next [9];
    logic signed [T_W-1:0]     t_reg [3];
    logic signed [T_W-1:0]     t_next [3];
    logic [ROW_W-1:0]          rows [3];

    assign rows[0] = row_x;
    assign rows[1] = row_y;
    assign rows[2] = row_z;

    assign d_next[0] = DIFF_W'(vx) - DIFF_W'(pos_x);
    assign d_next[1] = DIFF_W'(vy) - DIFF_W'(pos_y);
    assign d_next[2] = DIFF_W'(vz) - DIFF_W'(pos_z);

    for (genvar r = 0; r < 3; r++) begin : g_row
        for (genvar c = 0; c < 3; c++) begin : g_col
            assign prod_next[r*3+c] =
                PROD_W'($signed(rows[r][c*BASIS_W +: BASIS_W]) * d_reg[c]);
        end
        assign t_next[r] = T_W'(prod_reg[r*3]) + T_W'(prod_reg[r*3+1])
                         + T_W'(prod_reg[r*3+2]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg    <= d_next;
            prod_reg <= prod_next;
            t_reg    <= t_next;
        end
    end

    assign out_valid = valid_reg[2];
    assign tx = t_reg[0];
    assign ty = t_reg[1];
    assign tz = t_reg[2];
endmodule

// File: sv/vva_norm.sv
// Lane front end: magnitudes, special cases, leading-one search, normalize.
// Three register stages; depends on vva_pkg.
module vva_norm (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic signed [vva_pkg::T_W-1:0] a,
    input  logic signed [vva_pkg::T_W-1:0] z,
    output logic                           out_valid,
    output logic signed [vva_pkg::CW-1:0]  x_out,
    output logic signed [vva_pkg::CW-1:0]  y_out,
    output vva_pkg::vva_case_t             case_out
);
    import vva_pkg::*;

    logic [2:0]        valid_reg;
    logic [MAG_W-1:0]  ua_reg, uz_reg, m_reg;
    logic [MAG_W-1:0]  ua_next, uz_next, m_next;
    logic [MAG_W-1:0]  ua2_reg, uz2_reg;
    logic [SH_W-1:0]   sh_reg, sh_next;
    logic [SH_W-1:0]   msb;
    logic signed [CW-1:0] x_reg, y_reg;
    vva_case_t         c1_reg, c2_reg, c3_reg, c_next;

    assign ua_next = a[T_W-1] ? MAG_W'(-a) : MAG_W'(a);
    assign uz_next = z[T_W-1] ? MAG_W'(-z) : MAG_W'(z);
    assign m_next  = (ua_next > uz_next) ? ua_next : uz_next;
    assign c_next  = '{a_zero: (a == '0), z_zero: (z == '0),
                       a_neg: a[T_W-1], z_neg: z[T_W-1]};

    // Highest set bit of the larger magnitude.
    always_comb begin
        msb = '0;
        for (int k = 0; k < MAG_W; k++) begin
            if (m_reg[k]) begin
                msb = SH_W'(k);
            end
        end
        sh_next = SH_W'(NORM_MSB - int'(msb));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ua_reg  <= ua_next;
            uz_reg  <= uz_next;
            m_reg   <= m_next;
            c1_reg  <= c_next;
            ua2_reg <= ua_reg;
            uz2_reg <= uz_reg;
            sh_reg  <= sh_next;
            c2_reg  <= c1_reg;
            x_reg   <= CW'(uz2_reg) << sh_reg;
            y_reg   <= CW'(ua2_reg) << sh_reg;
            c3_reg  <= c2_reg;
        end
    end

    assign out_valid = valid_reg[2];
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign case_out  = c3_reg;
endmodule

// File: sv/vva_cordic.sv
// Lane back end: CORDIC vectoring stages, one register each, then the
// clamp, quadrant fold and Q9.7 rounding stage. Depends on vva_pkg.
module vva_cordic #(
    parameter int STAGES = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic signed [vva_pkg::CW-1:0]     x_in,
    input  logic signed [vva_pkg::CW-1:0]     y_in,
    input  vva_pkg::vva_case_t                case_in,
    output logic                              out_valid,
    output logic signed [vva_pkg::ANG_W-1:0]  angle,
    output logic                              undef
);
    import vva_pkg::*;

    logic [STAGES-1:0]       valid_reg;
    logic signed [CW-1:0]    x_reg [STAGES];
    logic signed [CW-1:0]    y_reg [STAGES];
    logic signed [ACC_W-1:0] acc_reg [STAGES];
    vva_case_t               case_reg [STAGES];
    logic                    fv_reg;
    logic signed [ANG_W-1:0] angle_reg, angle_next;
    logic                    undef_reg;
    logic signed [ACC_W-1:0] clamped, folded, rounded;
    vva_case_t               cl;

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        logic signed [CW-1:0]    xc, yc, xs, ys;
        logic signed [ACC_W-1:0] ac, step;
        logic                    vc;
        vva_case_t               cc;
        if (i == 0) begin : g_first
            assign xc = x_in;
            assign yc = y_in;
            assign ac = '0;
            assign vc = in_valid;
            assign cc = case_in;
        end else begin : g_next
            assign xc = x_reg[i-1];
            assign yc = y_reg[i-1];
            assign ac = acc_reg[i-1];
            assign vc = valid_reg[i-1];
            assign cc = case_reg[i-1];
        end
        assign xs   = xc >>> i;
        assign ys   = yc >>> i;
        assign step = ACC_W'(atan_deg_q16(5'(i)));

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i] <= 1'b0;
            end else if (en) begin
                valid_reg[i] <= vc;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                case_reg[i] <= cc;
                if (!yc[CW-1]) begin
                    x_reg[i]   <= xc + ys;
                    y_reg[i]   <= yc - xs;
                    acc_reg[i] <= ac + step;
                end else begin
                    x_reg[i]   <= xc - ys;
                    y_reg[i]   <= yc + xs;
                    acc_reg[i] <= ac - step;
                end
            end
        end
    end

    // Clamp to [0, 90 deg], fold for negative z, round to Q.7, apply sign.
    always_comb begin
        cl = case_reg[STAGES-1];
        clamped = acc_reg[STAGES-1];
        if (clamped < 0) begin
            clamped = '0;
        end else if (clamped > DEG90_Q16) begin
            clamped = DEG90_Q16;
        end
        folded  = cl.z_neg ? (DEG180_Q16 - clamped) : clamped;
        rounded = (folded + ROUND_Q7) >>> Q7_SHIFT;
        if (cl.a_zero && cl.z_zero) begin
            angle_next = '0;
        end else if (cl.a_zero) begin
            angle_next = cl.z_neg ? DEG180_Q7 : '0;
        end else if (cl.z_zero) begin
            angle_next = cl.a_neg ? -DEG90_Q7 : DEG90_Q7;
        end else begin
            angle_next = cl.a_neg ? -ANG_W'(rounded) : ANG_W'(rounded);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fv_reg <= 1'b0;
        end else if (en) begin
            fv_reg <= valid_reg[STAGES-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            angle_reg <= angle_next;
            undef_reg <= cl.a_zero && cl.z_zero;
        end
    end

    assign out_valid = fv_reg;
    assign angle     = angle_reg;
    assign undef     = undef_reg;
endmodule

// File: sv/vertex_view_angles.sv
// Top level of the vertex view angle block: config registers, pipeline
// lanes and output skid stage. Depends on vva_pkg, vva_xform, vva_norm,
// vva_cordic and vertex_view_angles_defines.svh.
//
// Usage:
//   s_ channel: one vertex per request, s_tdata = {vertex_z, vertex_y,
//   vertex_x}, each signed Q16.16. m_ channel: one result per vertex,
//   m_tdata = {vert_angle, horiz_angle} in signed Q9.7 degrees, m_tuser =
//   {vert_undefined, horiz_undefined}.
//   cfg channel: cfg_index selects camera position x/y/z (0..2) or basis
//   row x/y/z (3..5); other indexes are dropped. Write only while idle.
//   Throughput: one vertex per cycle while the output is not held. The
//   path from input request to m_tvalid runs through three transform
//   stages, three normalize stages, one stage per CORDIC iteration capped
//   at 24, one rounding stage and one output register.
//   Stall: when the output is held, the next pipeline result parks in a
//   skid register; only then does s_tready drop and the whole pipeline
//   hold, so no item is lost or repeated.
//   Reset: aresetn (synchronous, active low) clears all valid bits and
//   loads camera position 0 and the identity basis.
module vertex_view_angles #(
    parameter int ANGLE_STAGES = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,    // vertex_x[31:0], vertex_y[63:32], vertex_z[95:64]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // horiz_angle[15:0], vert_angle[31:16]
    output logic [1:0]  m_tuser,    // horiz_undefined[0], vert_undefined[1]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [53:0] cfg_data
);
    import vva_pkg::*;
`include "vertex_view_angles_defines.svh"

    localparam int STAGES = (ANGLE_STAGES > ATAN_LEN) ? ATAN_LEN : ANGLE_STAGES;

    // Configuration registers.
    logic signed [DATA_W-1:0] pos_x_reg, pos_y_reg, pos_z_reg;
    logic [ROW_W-1:0]         row_x_reg, row_y_reg, row_z_reg;

    // Pipeline interconnect.
    logic                  en;
    logic                  xf_valid;
    logic signed [T_W-1:0] tx, ty, tz;
    logic                  nh_valid, nv_valid;
    logic signed [CW-1:0]  hx, hy, vx, vy;
    vva_case_t             hcase, vcase;
    logic                  ch_valid, cv_valid;
    logic signed [ANG_W-1:0] h_angle, v_angle;
    logic                  h_undef, v_undef;

    // Output and skid registers.
    logic        ov_reg, sv_reg;
    logic [31:0] od_reg, sd_reg;
    logic [1:0]  ou_reg, su_reg;
    logic        take;
    logic [31:0] res_data;
    logic [1:0]  res_user;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            pos_z_reg <= '0;
            row_x_reg <= ROW_X_RST;
            row_y_reg <= ROW_Y_RST;
            row_z_reg <= ROW_Z_RST;
        end else if (cfg_valid) begin
            case (vva_reg_t'(cfg_index))
                REG_CAM_POS_X:   pos_x_reg <= cfg_data[DATA_W-1:0];
                REG_CAM_POS_Y:   pos_y_reg <= cfg_data[DATA_W-1:0];
                REG_CAM_POS_Z:   pos_z_reg <= cfg_data[DATA_W-1:0];
                REG_BASIS_ROW_X: row_x_reg <= cfg_data;
                REG_BASIS_ROW_Y: row_y_reg <= cfg_data;
                REG_BASIS_ROW_Z: row_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Advance the whole pipeline unless a result is parked in the skid.
    assign en       = !sv_reg;
    assign s_tready = en;

    vva_xform u_xform (
        .aclk, .aresetn, .en,
        .in_valid (s_tvalid),
        .vx       (s_tdata[31:0]),
        .vy       (s_tdata[63:32]),
        .vz       (s_tdata[95:64]),
        .pos_x    (pos_x_reg),
        .pos_y    (pos_y_reg),
        .pos_z    (pos_z_reg),
        .row_x    (row_x_reg),
        .row_y    (row_y_reg),
        .row_z    (row_z_reg),
        .out_valid(xf_valid),
        .tx, .ty, .tz
    );

    vva_norm u_norm_h (
        .aclk, .aresetn, .en,
        .in_valid (xf_valid),
        .a        (tx),
        .z        (tz),
        .out_valid(nh_valid),
        .x_out    (hx),
        .y_out    (hy),
        .case_out (hcase)
    );

    vva_norm u_norm_v (
        .aclk, .aresetn, .en,
        .in_valid (xf_valid),
        .a        (ty),
        .z        (tz),
        .out_valid(nv_valid),
        .x_out    (vx),
        .y_out    (vy),
        .case_out (vcase)
    );

    vva_cordic #(.STAGES(STAGES)) u_cordic_h (
        .aclk, .aresetn, .en,
        .in_valid (nh_valid),
        .x_in     (hx),
        .y_in     (hy),
        .case_in  (hcase),
        .out_valid(ch_valid),
        .angle    (h_angle),
        .undef    (h_undef)
    );

    vva_cordic #(.STAGES(STAGES)) u_cordic_v (
        .aclk, .aresetn, .en,
        .in_valid (nv_valid),
        .x_in     (vx),
        .y_in     (vy),
        .case_in  (vcase),
        .out_valid(cv_valid),
        .angle    (v_angle),
        .undef    (v_undef)
    );

    // A result leaves the pipeline on every advancing edge with a valid tail.
    assign take     = en && ch_valid;
    assign res_data = {v_angle, h_angle};
    assign res_user = {v_undef, h_undef};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
            sv_reg <= 1'b0;
        end else if (!ov_reg || m_tready) begin
            if (sv_reg) begin
                ov_reg <= 1'b1;
                sv_reg <= 1'b0;
            end else begin
                ov_reg <= take;
            end
        end else if (take) begin
            sv_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!ov_reg || m_tready) begin
            if (sv_reg) begin
                od_reg <= sd_reg;
                ou_reg <= su_reg;
            end else begin
                od_reg <= res_data;
                ou_reg <= res_user;
            end
        end else if (take) begin
            sd_reg <= res_data;
            su_reg <= res_user;
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = od_reg;
    assign m_tuser  = ou_reg;

    // Both lanes move in lockstep.
    `VVA_ASSERT(a_lanes_aligned, aclk, aresetn, (ch_valid == cv_valid))
    // A parked result implies the output register is occupied.
    `VVA_ASSERT(a_skid_needs_out, aclk, aresetn, (sv_reg |-> ov_reg))
    // The skid drains on the first accepted output.
    `VVA_ASSERT(a_skid_drains, aclk, aresetn, ((sv_reg && m_tready) |=> !sv_reg))
    // An undefined horizontal angle reads as zero.
    `VVA_ASSERT(a_undef_zero, aclk, aresetn,
        ((m_tvalid && m_tuser[0]) |-> (m_tdata[15:0] == '0)))
    // The horizontal angle stays within half a turn.
    `VVA_ASSERT(a_angle_range, aclk, aresetn,
        (m_tvalid |-> (($signed(m_tdata[15:0]) <= DEG180_Q7)
                    && ($signed(m_tdata[15:0]) >= -DEG180_Q7))))
endmodule
